>>> rtl/dispersion_fixation_detector_defines.svh
// Assertion macros shared by the dispersion fixation detector RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef DISPERSION_FIXATION_DETECTOR_DEFINES_SVH
`define DISPERSION_FIXATION_DETECTOR_DEFINES_SVH

// Same-cycle implication, disabled in reset
`define DFD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset
`define DFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/dfd_pkg.sv
// Shared types and constants for the dispersion fixation detector.
// No dependencies.
package dfd_pkg;

    localparam int COORD_W = 16;
    localparam int THR_W   = 16;
    localparam int DISP_W  = 17;

    // One gaze sample as it travels from the front queue to the back end
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } t_sample;

endpackage

>>> rtl/dispersion_fixation_detector.sv
// Top level of the dispersion fixation detector: config register, front queue, back end.
// Depends on dfd_pkg, dfd_front and dfd_back.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------------------
//  in      | input     | i_in_valid/o_in_ready  | i_sample_x, i_sample_y
//  out     | output    | o_out_valid/i_out_ready| o_fixating, o_fix_toggled,
//          |           |                        | o_dispersion_doubled
//  cfg     | input     | i_cfg_we               | i_cfg_wdata (dispersion threshold)
//
// Each sample is processed in the back end by a walk over the window memory through its single
// registered read port; the back end takes the next sample only once it is idle again.
// The front queue holds two samples, so input transfers continue while the back end works.
// Synchronous active-low reset empties the window, clears the fixation flag and threshold.
// A stalled result holds in the output register; the back end waits before loading the next.
module dispersion_fixation_detector #(
    parameter int WINDOW = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [15:0] i_sample_x,
    input  logic signed [15:0] i_sample_y,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_fixating,
    output logic               o_fix_toggled,
    output logic [16:0]        o_dispersion_doubled,
    input  logic               i_cfg_we,
    input  logic [15:0]        i_cfg_wdata
);
    import dfd_pkg::*;

    logic [THR_W-1:0] r_threshold;
    logic             q_valid;
    logic             q_ready;
    t_sample          q_data;

    // Hold the threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= '0;
        end else if (i_cfg_we) begin
            r_threshold <= i_cfg_wdata;
        end
    end

    dfd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_in_valid),
        .o_ready    (o_in_ready),
        .i_sample_x (i_sample_x),
        .i_sample_y (i_sample_y),
        .o_q_valid  (q_valid),
        .i_q_ready  (q_ready),
        .o_q_data   (q_data)
    );

    dfd_back #(
        .WINDOW (WINDOW)
    ) u_back (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_threshold          (r_threshold),
        .i_q_valid            (q_valid),
        .o_q_ready            (q_ready),
        .i_q_data             (q_data),
        .o_valid              (o_out_valid),
        .i_ready              (i_out_ready),
        .o_fixating           (o_fixating),
        .o_fix_toggled        (o_fix_toggled),
        .o_dispersion_doubled (o_dispersion_doubled)
    );

endmodule

>>> rtl/dfd_front.sv
// Front end: accepts gaze samples and holds them in a two-entry queue.
// Depends on dfd_pkg.
module dfd_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic signed [15:0]     i_sample_x,
    input  logic signed [15:0]     i_sample_y,
    output logic                   o_q_valid,
    input  logic                   i_q_ready,
    output dfd_pkg::t_sample       o_q_data
);
    import dfd_pkg::*;

    t_sample    r_buf [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       push;
    logic       pop;

    assign o_ready   = (r_count != 2'd2);
    assign o_q_valid = (r_count != 2'd0);
    assign o_q_data  = r_buf[r_rd_ptr];
    assign push      = i_valid && o_ready;
    assign pop       = o_q_valid && i_q_ready;

    // Store the incoming transfer
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wr_ptr] <= '{x: i_sample_x, y: i_sample_y};
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) r_wr_ptr <= ~r_wr_ptr;
            if (pop)  r_rd_ptr <= ~r_rd_ptr;
            case ({push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> rtl/dfd_back.sv
// Back end: window memory, serial min/max walk, range sum and result register.
// Depends on dfd_pkg and dispersion_fixation_detector_defines.svh.
`include "dispersion_fixation_detector_defines.svh"

module dfd_back #(
    parameter int WINDOW = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [15:0]            i_threshold,
    input  logic                   i_q_valid,
    output logic                   o_q_ready,
    input  dfd_pkg::t_sample       i_q_data,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic                   o_fixating,
    output logic                   o_fix_toggled,
    output logic [16:0]            o_dispersion_doubled
);
    import dfd_pkg::*;

    localparam int AW = $clog2(WINDOW);
    localparam int CW = $clog2(WINDOW + 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_RANGE = 4'b0100,
        S_OUT   = 4'b1000
    } t_state;

    t_state                    r_state;
    t_sample                   r_mem [WINDOW];
    t_sample                   r_rd_data;
    logic [AW-1:0]             r_wr_ptr;
    logic [CW-1:0]             r_fill;
    logic [CW-1:0]             r_idx;
    logic                      r_dv;
    logic                      r_first;
    logic signed [COORD_W-1:0] r_lo_x, r_hi_x, r_lo_y, r_hi_y;
    logic [COORD_W-1:0]        r_rng_x, r_rng_y;
    logic                      r_fix;
    logic                      r_out_valid;
    logic                      r_out_fix;
    logic                      r_out_chg;
    logic [DISP_W-1:0]         r_out_disp;

    logic                      mem_we;
    logic                      rd_en;
    logic                      slot_free;
    logic [COORD_W-1:0]        diff_x, diff_y;
    logic [DISP_W-1:0]         sum;
    logic                      now_fix;

    assign o_q_ready = (r_state == S_IDLE);
    assign mem_we    = o_q_ready && i_q_valid;
    assign rd_en     = (r_idx < r_fill);
    assign slot_free = !r_out_valid || i_ready;

    // Range per axis; max minus min always fits in 16 unsigned bits
    assign diff_x = r_hi_x - r_lo_x;
    assign diff_y = r_hi_y - r_lo_y;

    // Sum ranges and compare against twice the threshold
    assign sum     = {1'b0, r_rng_x} + {1'b0, r_rng_y};
    assign now_fix = (sum < {i_threshold, 1'b0});

    // Window memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_wr_ptr] <= i_q_data;
        end
        r_rd_data <= r_mem[r_idx[AW-1:0]];
    end

    // Control sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wr_ptr    <= '0;
            r_fill      <= '0;
            r_idx       <= '0;
            r_dv        <= 1'b0;
            r_fix       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_OUT && slot_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_wr_ptr <= (r_wr_ptr == AW'(WINDOW - 1)) ? '0 : r_wr_ptr + 1'b1;
                        if (r_fill != CW'(WINDOW)) r_fill <= r_fill + 1'b1;
                        r_idx   <= '0;
                        r_dv    <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (rd_en) r_idx <= r_idx + 1'b1;
                    r_dv <= rd_en;
                    if (!rd_en && !r_dv) r_state <= S_RANGE;
                end
                S_RANGE: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (slot_free) begin
                        r_fix   <= now_fix;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath: min/max walk, ranges, result payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) begin
            r_first <= 1'b1;
        end
        if (r_state == S_SCAN && r_dv) begin
            r_first <= 1'b0;
            if (r_first || r_rd_data.x < r_lo_x) r_lo_x <= r_rd_data.x;
            if (r_first || r_rd_data.x > r_hi_x) r_hi_x <= r_rd_data.x;
            if (r_first || r_rd_data.y < r_lo_y) r_lo_y <= r_rd_data.y;
            if (r_first || r_rd_data.y > r_hi_y) r_hi_y <= r_rd_data.y;
        end
        if (r_state == S_RANGE) begin
            // Fewer than two samples held gives zero dispersion
            r_rng_x <= (r_fill < CW'(2)) ? '0 : diff_x;
            r_rng_y <= (r_fill < CW'(2)) ? '0 : diff_y;
        end
        if (r_state == S_OUT && slot_free) begin
            r_out_fix  <= now_fix;
            r_out_chg  <= now_fix != r_fix;
            r_out_disp <= sum;
        end
    end

    assign o_valid              = r_out_valid;
    assign o_fixating           = r_out_fix;
    assign o_fix_toggled        = r_out_chg;
    assign o_dispersion_doubled = r_out_disp;

    `DFD_ASSERT_NOW(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= CW'(WINDOW),
        "fill count exceeds window depth")
    `DFD_ASSERT_NOW(a_scan_nonempty, i_clk, i_rst_n, r_state == S_SCAN, r_fill != '0,
        "window walk started on an empty window")
    `DFD_ASSERT_NOW(a_idx_bound, i_clk, i_rst_n, 1'b1, r_idx <= r_fill,
        "read index ran past the held samples")
    `DFD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n,
        r_state == S_OUT && r_out_valid && !i_ready, r_state == S_OUT,
        "result loaded over a pending transfer")

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for dispersion_fixation_detector against a windowed-range predictor.
// Depends on dfd_pkg and the detector RTL.
module tb_top;
    import dfd_pkg::*;

    localparam int WIN         = 16;
    localparam int CYCLE_LIMIT = 600000;

    // Expected outcome of one gaze sample
    typedef struct {
        bit              fix;
        bit              chg;
        bit [DISP_W-1:0] disp;
    } t_verdict;

    // Sliding gaze window, fixation state and threshold; queues expected verdicts
    class t_fixation_tracker;
        int                  depth;
        logic signed [15:0]  win_x[$];
        logic signed [15:0]  win_y[$];
        bit                  fix_state;
        bit [THR_W-1:0]      threshold;
        t_verdict            pending_verdicts[$];
        int                  errors;

        function new(int win_depth);
            depth     = win_depth;
            fix_state = 1'b0;
            threshold = '0;
            errors    = 0;
        endfunction

        function void set_threshold(bit [THR_W-1:0] value);
            threshold = value;
        endfunction

        function int pending_count();
            return pending_verdicts.size();
        endfunction

        // Push the sample, drop the oldest once full, then take both axis ranges
        function void note_sample(logic signed [15:0] x, logic signed [15:0] y);
            int       lo_x, hi_x, lo_y, hi_y;
            int       spread;
            t_verdict v;
            win_x.push_back(x);
            win_y.push_back(y);
            if (win_x.size() > depth) begin
                void'(win_x.pop_front());
                void'(win_y.pop_front());
            end
            spread = 0;
            if (win_x.size() >= 2) begin
                lo_x = win_x[0];
                hi_x = win_x[0];
                lo_y = win_y[0];
                hi_y = win_y[0];
                foreach (win_x[i]) begin
                    if (win_x[i] < lo_x) lo_x = win_x[i];
                    if (win_x[i] > hi_x) hi_x = win_x[i];
                    if (win_y[i] < lo_y) lo_y = win_y[i];
                    if (win_y[i] > hi_y) hi_y = win_y[i];
                end
                spread = (hi_x - lo_x) + (hi_y - lo_y);
            end
            v.fix  = (spread < 2 * int'(threshold));
            v.chg  = (v.fix != fix_state);
            v.disp = spread[DISP_W-1:0];
            fix_state = v.fix;
            pending_verdicts.push_back(v);
        endfunction

        // Compare one output transfer against the oldest expectation
        function void check_verdict(bit fix, bit chg, bit [DISP_W-1:0] disp);
            t_verdict want;
            if (pending_verdicts.size() == 0) begin
                $display("%0t: result with nothing expected: fix %0d chg %0d disp %0d",
                         $time, fix, chg, disp);
                errors++;
                return;
            end
            want = pending_verdicts.pop_front();
            if (fix != want.fix) begin
                $display("%0t: fixating expected %0d actual %0d", $time, want.fix, fix);
                errors++;
            end
            if (chg != want.chg) begin
                $display("%0t: fix_toggled expected %0d actual %0d", $time, want.chg, chg);
                errors++;
            end
            if (disp != want.disp) begin
                $display("%0t: dispersion_doubled expected %0d actual %0d",
                         $time, want.disp, disp);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic signed [15:0] i_sample_x;
    logic signed [15:0] i_sample_y;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic               o_fixating;
    logic               o_fix_toggled;
    logic [16:0]        o_dispersion_doubled;
    logic               i_cfg_we;
    logic [15:0]        i_cfg_wdata;

    t_fixation_tracker tracker;
    int                send_idle_pct = 15;
    int                take_idle_pct = 15;
    int                cycle_count   = 0;
    int                phase_thr[8];

    dispersion_fixation_detector #(
        .WINDOW(WIN)
    ) uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_sample_x          (i_sample_x),
        .i_sample_y          (i_sample_y),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_fixating          (o_fixating),
        .o_fix_toggled       (o_fix_toggled),
        .o_dispersion_doubled(o_dispersion_doubled),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_wdata         (i_cfg_wdata)
    );

    always #6 i_clk = ~i_clk;

    // Bound the run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Check each output transfer, then pick the next ready at random
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && i_out_ready && o_out_valid === 1'b1) begin
            tracker.check_verdict(o_fixating, o_fix_toggled, o_dispersion_doubled);
        end
        i_out_ready <= ($urandom_range(99) >= take_idle_pct);
    end

    function automatic int clip16(int v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // Offer one sample after a random gap; hold it until the transfer
    task automatic send_sample(input int x, input int y);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample_x <= 16'(x);
        i_sample_y <= 16'(y);
        @(posedge i_clk);
        while (o_in_ready !== 1'b1) @(posedge i_clk);
        tracker.note_sample(16'(x), 16'(y));
    endtask

    // Let every expected result arrive, then allow the back end to settle
    task automatic wait_drained();
        while (tracker.pending_count() != 0) @(posedge i_clk);
        repeat (2 * WIN + 8) @(posedge i_clk);
    endtask

    task automatic write_threshold(input int value);
        i_in_valid <= 1'b0;
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= 16'(value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        tracker.set_threshold(16'(value));
    endtask

    // Mostly fixation clusters around random centers; some full-range noise samples
    task automatic run_gaze_stream(input int count);
        int sent, span, jitter, cx, cy;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(99) < 10) begin
                send_sample(int'($urandom_range(65535)) - 32768,
                            int'($urandom_range(65535)) - 32768);
                sent++;
            end else begin
                cx = int'($urandom_range(65535)) - 32768;
                cy = int'($urandom_range(65535)) - 32768;
                case ($urandom_range(3))
                    0: jitter = 0;
                    1: jitter = 3;
                    2: jitter = 60;
                    default: jitter = 1500;
                endcase
                span = $urandom_range(40, 4);
                if (span > count - sent) span = count - sent;
                repeat (span) begin
                    send_sample(clip16(cx + int'($urandom_range(2 * jitter)) - jitter),
                                clip16(cy + int'($urandom_range(2 * jitter)) - jitter));
                    sent++;
                end
            end
        end
    endtask

    initial begin
        tracker = new(WIN);
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_sample_x  <= '0;
        i_sample_y  <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Small threshold: single-sample window, tiny spreads, then full-range extremes
        write_threshold(3);
        send_sample(0, 0);
        send_sample(0, 0);
        send_sample(1, -1);
        send_sample(2, -1);
        send_sample(-32768, -32768);
        send_sample(32767, 32767);
        send_sample(32767, -32768);
        send_sample(-32768, 32767);

        // Largest threshold: widest spread sits exactly at the limit, so no fixation
        write_threshold(65535);
        send_sample(0, 0);
        send_sample(-1, -1);
        send_sample(32767, 0);
        send_sample(0, -32768);

        // Zero threshold: nothing fixates
        write_threshold(0);
        send_sample(5, 5);
        send_sample(-5, 5);
        send_sample(0, 0);

        // Random phases over a spread of thresholds; one phase runs with no idling
        phase_thr = '{0, 1, 65535, 40, 200, 1200, 0, 0};
        phase_thr[6] = $urandom_range(65535);
        phase_thr[7] = $urandom_range(3000, 2);
        for (int p = 0; p < 8; p++) begin
            write_threshold(phase_thr[p]);
            send_idle_pct = (p == 2) ? 0 : 15;
            take_idle_pct = (p == 2) ? 0 : 15;
            run_gaze_stream(216);
        end

        i_in_valid <= 1'b0;
        wait_drained();
        if (tracker.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

>>> sim.f
+incdir+rtl
rtl/dfd_pkg.sv
rtl/dfd_front.sv
rtl/dfd_back.sv
rtl/dispersion_fixation_detector.sv
dv/tb_top.sv
